### rtl/lvu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lvu_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_DAMPING_RATE   = 2'd0;
  localparam logic [1:0] REG_TIME_STEP      = 2'd1;
  localparam logic [1:0] REG_NOISE_STRENGTH = 2'd2;

  localparam logic [23:0] DAMPING_RESET   = 24'd0;
  localparam logic [23:0] TIME_STEP_RESET = 24'd65536;
  localparam logic [31:0] NOISE_RESET     = 32'd0;

  // 48-bit linear congruential generator: X = A * X + C mod 2^48.
  localparam logic [47:0] LCG_SEED   = 48'h1234ABCD330E;
  localparam logic [31:0] LCG_MUL_LO = 32'hDEECE66D;
  localparam logic [31:0] LCG_MUL_HI = 32'h00000005;
  localparam logic [47:0] LCG_ADD    = 48'h00000000000B;

  // One in the format of gamma*dt (32 fraction bits) is two halves of the step.
  localparam logic [47:0] K_ONE = 48'h000200000000;

  // Accumulator width is ACC_BASE - VEL_FRAC_BITS, the rounding shift is
  // ROUND_BASE - VEL_FRAC_BITS.
  localparam int ACC_BASE   = 114;
  localparam int ROUND_BASE = 65;

  localparam logic [31:0] VEL_MAX  = 32'h7FFFFFFF;
  localparam logic [31:0] VEL_MIN  = 32'h80000000;
  localparam logic [31:0] HALF_ONE = 32'h80000000;
  localparam logic [1:0]  LAST_COMP = 2'd2;

  typedef struct packed {
    logic               action;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               saturated;
  } out_beat_t;

  typedef enum logic [3:0] {
    UOP_GDT,
    UOP_NOP,
    UOP_LCG0,
    UOP_LCG1,
    UOP_LCG2,
    UOP_DMP_LO,
    UOP_NS_R,
    UOP_DMP_HI,
    UOP_NZ_LO,
    UOP_NZ_HI
  } uop_e;

  typedef struct packed {
    logic       valid;
    uop_e       code;
    logic [1:0] comp;
    logic       last;
  } uop_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_V,
    SH_V32
  } shift_e;

  typedef enum logic {
    PRE_LCG,
    PRE_HALF
  } pre_e;

  typedef struct packed {
    logic   en;
    logic   clear;
    logic   neg;
    shift_e shift;
    pre_e   pre;
  } acc_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    uop_t uop;
    logic load_out;
  } seq_ctl_t;

  typedef struct packed {
    logic res_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/langevin_velocity_update.sv
`timescale 1ns / 1ps
`default_nettype none

// Langevin velocity half step for one particle per beat. Action 0 applies
// v * (1 - gamma*dt/2); action 1 adds the noise term c*r*dt/2 with one
// uniform draw in [-1/2, 1/2) per component, drawn in x, y, z order from a
// 48-bit drand48-style generator kept inside the block (seeded at reset).
// Each component is computed exactly, rounded half up once and saturated to
// 32 bits; saturated flags any clipped component. All products go through a
// single 32x32 multiplier: an action 1 beat issues gamma*dt, then per
// component three generator partial products, two damping partial
// products, c*|r| and two partial products with dt; an action 0 beat issues
// gamma*dt, one wait and two damping partial products per component. After
// the accumulator drains, the result is handed over to the output register
// once that register is free, and the block goes idle to take the next
// beat; it takes no new beat while one is in flight. The result sits in its
// own output register, so the next beat is taken while it waits.
// Configuration may be written only while the block is idle.
module langevin_velocity_update #(
  parameter int VEL_FRAC_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  lvu_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output lvu_pkg::out_beat_t  out_data_o,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_index_i,
  input  wire  [31:0]         cfg_data_i
);
  import lvu_pkg::*;

  localparam int ACC_W       = ACC_BASE - VEL_FRAC_BITS;
  localparam int ROUND_SHIFT = ROUND_BASE - VEL_FRAC_BITS;
  localparam int Q_W         = ACC_W - ROUND_SHIFT;

  // Configuration registers.
  logic [23:0] gamma_q;
  logic [23:0] dt_q;
  logic [31:0] noise_q;

  // Generator state and per-item intermediates.
  logic [47:0] lcg_q;
  logic [47:0] kmag_q;
  logic        kneg_q;
  logic [62:0] p_q;
  in_beat_t    in_q;

  // Pipeline: the micro-op in the accumulate stage and the finish flag.
  uop_t        uop_a_q;
  logic        fin_q;
  logic [1:0]  fin_comp_q;

  out_beat_t   res_q;
  out_beat_t   out_q;
  logic        out_valid_q;

  seq_ctl_t    seq_ctl;
  dp_status_t  status;
  logic        in_accept;

  logic        mul_en;
  logic [31:0] op_a;
  logic [31:0] op_b;
  acc_ctl_t    acc_ctl;
  logic [63:0] prod;
  logic [ACC_W-1:0] acc_d;
  logic [ACC_W-1:0] acc;

  logic [31:0] vmag_issue;
  logic [31:0] vel_a;
  logic        dneg;
  logic        rneg;
  logic [31:0] rmag;
  logic [31:0] draw;

  logic [Q_W-1:0] quot;
  logic           fits;
  logic [31:0]    fin_val;
  logic           fin_sat;

  logic [47:0] gdt;
  logic        gdt_gt;

  assign in_accept = in_valid_i && !in_stall_o;

  lvu_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (in_data_i.action),
    .status_i   (status),
    .ctl_o      (seq_ctl)
  );

  lvu_mac #(
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .mul_en_i  (mul_en),
    .op_a_i    (op_a),
    .op_b_i    (op_b),
    .acc_ctl_i (acc_ctl),
    .prod_o    (prod),
    .acc_d_o   (acc_d),
    .acc_o     (acc)
  );

  function automatic logic [31:0] vel_sel(input in_beat_t b, input logic [1:0] comp);
    logic [31:0] v;
    case (comp)
      2'd0:    v = b.vel_x;
      2'd1:    v = b.vel_y;
      default: v = b.vel_z;
    endcase
    return v;
  endfunction

  // The uniform draw is the top 32 bits of the generator, offset by one half.
  assign draw = lcg_q[47:16];
  assign rneg = !draw[31];
  assign rmag = draw[31] ? {1'b0, draw[30:0]} : (HALF_ONE - draw);

  // Magnitude of the velocity component; the most negative value gives 2^31.
  always_comb begin
    vmag_issue = vel_sel(in_q, seq_ctl.uop.comp);
    if (vmag_issue[31]) begin
      vmag_issue = ~vmag_issue + 32'd1;
    end
  end

  // Operand selection for the micro-op entering the multiplier.
  always_comb begin
    mul_en = seq_ctl.uop.valid && (seq_ctl.uop.code != UOP_NOP);
    op_a   = '0;
    op_b   = '0;
    unique case (seq_ctl.uop.code)
      UOP_GDT: begin
        op_a = {8'b0, gamma_q};
        op_b = {8'b0, dt_q};
      end
      UOP_LCG0: begin
        op_a = LCG_MUL_LO;
        op_b = lcg_q[31:0];
      end
      UOP_LCG1: begin
        op_a = LCG_MUL_LO;
        op_b = {16'b0, lcg_q[47:32]};
      end
      UOP_LCG2: begin
        op_a = LCG_MUL_HI;
        op_b = lcg_q[31:0];
      end
      UOP_DMP_LO: begin
        op_a = kmag_q[31:0];
        op_b = vmag_issue;
      end
      UOP_NS_R: begin
        op_a = noise_q;
        op_b = rmag;
      end
      UOP_DMP_HI: begin
        op_a = {16'b0, kmag_q[47:32]};
        op_b = vmag_issue;
      end
      UOP_NZ_LO: begin
        op_a = p_q[31:0];
        op_b = {8'b0, dt_q};
      end
      UOP_NZ_HI: begin
        op_a = {1'b0, p_q[62:32]};
        op_b = {8'b0, dt_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Accumulate-stage control. The damping term is signed by the signs of
  // the velocity and of the factor k; the noise term by the sign of r.
  assign vel_a = vel_sel(in_q, uop_a_q.comp);
  assign dneg  = vel_a[31] ^ kneg_q;

  always_comb begin
    acc_ctl.en    = 1'b0;
    acc_ctl.clear = 1'b0;
    acc_ctl.neg   = 1'b0;
    acc_ctl.shift = SH_0;
    acc_ctl.pre   = PRE_HALF;
    if (uop_a_q.valid) begin
      unique case (uop_a_q.code)
        UOP_LCG0: begin
          acc_ctl.en    = 1'b1;
          acc_ctl.clear = 1'b1;
          acc_ctl.pre   = PRE_LCG;
        end
        UOP_LCG1, UOP_LCG2: begin
          acc_ctl.en    = 1'b1;
          acc_ctl.shift = SH_32;
        end
        UOP_DMP_LO: begin
          acc_ctl.en    = 1'b1;
          acc_ctl.clear = 1'b1;
          acc_ctl.neg   = dneg;
          acc_ctl.shift = SH_V;
        end
        UOP_DMP_HI: begin
          acc_ctl.en    = 1'b1;
          acc_ctl.neg   = dneg;
          acc_ctl.shift = SH_V32;
        end
        UOP_NZ_LO: begin
          acc_ctl.en    = 1'b1;
          acc_ctl.neg   = rneg;
        end
        UOP_NZ_HI: begin
          acc_ctl.en    = 1'b1;
          acc_ctl.neg   = rneg;
          acc_ctl.shift = SH_32;
        end
        default: acc_ctl.en = 1'b0;
      endcase
    end
  end

  // k = 1 - gamma*dt/2 kept as sign and magnitude.
  assign gdt    = prod[47:0];
  assign gdt_gt = gdt > K_ONE;

  // Rounding was preloaded into the accumulator, so finishing is a shift
  // and a range check.
  assign quot = acc[ACC_W-1:ROUND_SHIFT];
  assign fits = (&quot[Q_W-1:31]) || !(|quot[Q_W-1:31]);
  always_comb begin
    fin_sat = !fits;
    if (fits) begin
      fin_val = quot[31:0];
    end else begin
      fin_val = quot[Q_W-1] ? VEL_MIN : VEL_MAX;
    end
  end

  assign status.res_done = fin_q && (fin_comp_q == LAST_COMP);
  assign status.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q     <= DAMPING_RESET;
      dt_q        <= TIME_STEP_RESET;
      noise_q     <= NOISE_RESET;
      lcg_q       <= LCG_SEED;
      uop_a_q     <= '0;
      fin_q       <= 1'b0;
      fin_comp_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DAMPING_RATE:   gamma_q <= cfg_data_i[23:0];
          REG_TIME_STEP:      dt_q    <= cfg_data_i[23:0];
          REG_NOISE_STRENGTH: noise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (uop_a_q.valid && (uop_a_q.code == UOP_LCG2)) begin
        lcg_q <= acc_d[47:0];
      end
      uop_a_q    <= seq_ctl.uop;
      fin_q      <= uop_a_q.valid && uop_a_q.last;
      fin_comp_q <= uop_a_q.comp;
      if (seq_ctl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (uop_a_q.valid && (uop_a_q.code == UOP_GDT)) begin
      kneg_q <= gdt_gt;
      kmag_q <= gdt_gt ? (gdt - K_ONE) : (K_ONE - gdt);
    end
    if (uop_a_q.valid && (uop_a_q.code == UOP_NS_R)) begin
      p_q <= prod[62:0];
    end
    if (fin_q) begin
      case (fin_comp_q)
        2'd0: begin
          res_q.new_x     <= fin_val;
          res_q.saturated <= fin_sat;
        end
        2'd1: begin
          res_q.new_y     <= fin_val;
          res_q.saturated <= res_q.saturated | fin_sat;
        end
        default: begin
          res_q.new_z     <= fin_val;
          res_q.saturated <= res_q.saturated | fin_sat;
        end
      endcase
    end
    if (seq_ctl.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // When the block takes a beat, nothing of the previous one is still in
  // the accumulate or finish stage.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!uop_a_q.valid && !fin_q))
    else $error("beat accepted while the datapath still holds work");

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_ctl.load_out |-> status.out_free)
    else $error("output register loaded while its beat is pending");

  // The last component finishes only while an item is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_done |-> in_stall_o)
    else $error("result completed while the block is idle");

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (in_stall_o && seq_ctl.uop.valid))
    else $error("sequencer did not start after an accepted beat");
`endif

endmodule

`default_nettype wire

### rtl/lvu_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared 32x32 multiplier with a registered product, followed by a wide
// shift, negate and accumulate stage.
module lvu_mac #(
  parameter int VEL_FRAC_BITS = 16
) (
  input  wire                                         clk_i,
  input  wire                                         mul_en_i,
  input  wire  [31:0]                                 op_a_i,
  input  wire  [31:0]                                 op_b_i,
  input  lvu_pkg::acc_ctl_t                           acc_ctl_i,
  output logic [63:0]                                 prod_o,
  output logic [lvu_pkg::ACC_BASE-VEL_FRAC_BITS-1:0]  acc_d_o,
  output logic [lvu_pkg::ACC_BASE-VEL_FRAC_BITS-1:0]  acc_o
);
  import lvu_pkg::*;

  localparam int ACC_W       = ACC_BASE - VEL_FRAC_BITS;
  localparam int VSHIFT      = 32 - VEL_FRAC_BITS;
  localparam int PW          = 96 + VSHIFT;
  localparam int ROUND_SHIFT = ROUND_BASE - VEL_FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF_LSB = {{(ACC_W-1){1'b0}}, 1'b1} << (ROUND_SHIFT - 1);

  logic [63:0]     prod_q;
  logic [ACC_W-1:0] acc_q;
  logic [PW-1:0]   wide;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] base;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= op_a_i * op_b_i;
    end
    if (acc_ctl_i.en) begin
      acc_q <= acc_d_o;
    end
  end

  always_comb begin
    unique case (acc_ctl_i.shift)
      SH_0:    wide = {{(PW-64){1'b0}}, prod_q};
      SH_32:   wide = {{VSHIFT{1'b0}}, prod_q, 32'b0};
      SH_V:    wide = {32'b0, prod_q, {VSHIFT{1'b0}}};
      SH_V32:  wide = {prod_q, {(VSHIFT+32){1'b0}}};
      default: wide = '0;
    endcase
    term = acc_ctl_i.neg ? (~wide[ACC_W-1:0] + 1'b1) : wide[ACC_W-1:0];
    if (acc_ctl_i.clear) begin
      base = (acc_ctl_i.pre == PRE_HALF) ? HALF_LSB : {{(ACC_W-48){1'b0}}, LCG_ADD};
    end else begin
      base = acc_q;
    end
    acc_d_o = base + term;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

### rtl/lvu_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Micro-op sequencer: walks the product list of one item through the
// shared multiplier, one micro-op per cycle.
module lvu_seq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 action_i,
  input  lvu_pkg::dp_status_t status_i,
  output lvu_pkg::seq_ctl_t   ctl_o
);
  import lvu_pkg::*;

  seq_state_e state_q, state_d;
  uop_e       code_q, code_d;
  logic [1:0] comp_q, comp_d;
  logic       act_q, act_d;
  logic       last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= UOP_GDT;
      comp_q  <= '0;
      act_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      comp_q  <= comp_d;
      act_q   <= act_d;
    end
  end

  assign last = ((code_q == UOP_DMP_HI) && !act_q) || (code_q == UOP_NZ_HI);

  always_comb begin
    state_d        = state_q;
    code_d         = code_q;
    comp_d         = comp_q;
    act_d          = act_q;
    in_stall_o     = 1'b1;
    ctl_o.load_out = 1'b0;
    ctl_o.uop.valid = (state_q == S_RUN);
    ctl_o.uop.code  = code_q;
    ctl_o.uop.comp  = comp_q;
    ctl_o.uop.last  = last;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          act_d   = action_i;
          comp_d  = '0;
          code_d  = UOP_GDT;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (last) begin
          if (comp_q == LAST_COMP) begin
            state_d = S_DRAIN;
          end else begin
            comp_d = comp_q + 2'd1;
            code_d = act_q ? UOP_LCG0 : UOP_DMP_LO;
          end
        end else begin
          unique case (code_q)
            UOP_GDT:    code_d = act_q ? UOP_LCG0 : UOP_NOP;
            UOP_NOP:    code_d = UOP_DMP_LO;
            UOP_LCG0:   code_d = UOP_LCG1;
            UOP_LCG1:   code_d = UOP_LCG2;
            UOP_LCG2:   code_d = UOP_DMP_LO;
            UOP_DMP_LO: code_d = act_q ? UOP_NS_R : UOP_DMP_HI;
            UOP_NS_R:   code_d = UOP_DMP_HI;
            UOP_DMP_HI: code_d = UOP_NZ_LO;
            UOP_NZ_LO:  code_d = UOP_NZ_HI;
            default:    code_d = UOP_GDT;
          endcase
        end
      end
      S_DRAIN: begin
        if (status_i.res_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lvu_pkg::*;

  // The block is built with the default velocity format; the bench mirrors it.
  localparam int VEL_FRAC = 16;

  // Cycles in which no beat moves on either channel before the run is declared hung.
  // The longest correct silence is the output hold-off plus one action 1 beat
  // plus the longest sender gap, so this is several times that.
  localparam int IDLE_LIMIT = 3000;

  // An index past the last register; writes to it must leave everything alone.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // The generator multiplier as one 48-bit constant.
  localparam logic [47:0] LCG_A = {LCG_MUL_HI[15:0], LCG_MUL_LO};

  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  // Keeps a private copy of the registers and the noise generator, computes the
  // velocity each accepted beat should produce, and checks the results in order.
  class velocity_board;
    logic [23:0] gamma;
    logic [23:0] dt;
    logic [31:0] c;
    logic [47:0] lcg;
    out_beat_t awaited_vel[$];
    int fails;
    int checked;
    int noisy;
    int clipped;

    function new();
      gamma = DAMPING_RESET;
      dt = TIME_STEP_RESET;
      c = NOISE_RESET;
      lcg = LCG_SEED;
    endfunction

    // The 24-bit registers keep only their low bits; an unknown index is dropped.
    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_DAMPING_RATE: gamma = val[23:0];
        REG_TIME_STEP: dt = val[23:0];
        REG_NOISE_STRENGTH: c = val;
        default: ;
      endcase
    endfunction

    task report(string msg);
      fails++;
      $display("tb: mismatch: %s", msg);
    endtask

    // Each component is v*(2^33 - gamma*dt), moved up to the common scale, plus
    // c*r*dt for a noisy beat. That sum carries 65 fraction bits in all.
    // It is rounded half up once and clipped to 32 bits.
    function void note_beat(in_beat_t b);
      logic signed [31:0] comp_in [3];
      logic signed [31:0] comp_out [3];
      logic signed [127:0] k;
      logic signed [127:0] acc;
      logic signed [127:0] q;
      logic signed [127:0] r;
      logic [31:0] d;
      bit clip;
      out_beat_t e;
      comp_in[0] = b.vel_x;
      comp_in[1] = b.vel_y;
      comp_in[2] = b.vel_z;
      clip = 1'b0;
      // A gamma*dt above two makes k negative; it is used as it is.
      k = (128'sd1 <<< 33) - $signed({104'd0, gamma}) * $signed({104'd0, dt});
      if (b.action) noisy++;
      for (int i = 0; i < 3; i++) begin
        acc = comp_in[i];
        acc = (k * acc) <<< (32 - VEL_FRAC);
        if (b.action) begin
          // One generator step per component, x first; r = top 32 bits - 2^31.
          lcg = LCG_A * lcg + LCG_ADD;
          d = lcg[47:16];
          r = $signed({96'd0, d}) - (128'sd1 <<< 31);
          acc = acc + $signed({96'd0, c}) * r * $signed({104'd0, dt});
        end
        q = (acc + (128'sd1 <<< (ROUND_BASE - VEL_FRAC - 1))) >>> (ROUND_BASE - VEL_FRAC);
        if (q > Q_MAX) begin
          comp_out[i] = VEL_MAX;
          clip = 1'b1;
        end else if (q < Q_MIN) begin
          comp_out[i] = VEL_MIN;
          clip = 1'b1;
        end else begin
          comp_out[i] = q[31:0];
        end
      end
      e.new_x = comp_out[0];
      e.new_y = comp_out[1];
      e.new_z = comp_out[2];
      e.saturated = clip;
      if (clip) clipped++;
      awaited_vel.push_back(e);
    endfunction

    task check_beat(out_beat_t got);
      out_beat_t e;
      if (awaited_vel.size() == 0) begin
        report($sformatf("result %h arrived with no beat outstanding", got));
      end else begin
        e = awaited_vel.pop_front();
        if (got.new_x !== e.new_x)
          report($sformatf("beat %0d new_x got %h want %h", checked, got.new_x, e.new_x));
        if (got.new_y !== e.new_y)
          report($sformatf("beat %0d new_y got %h want %h", checked, got.new_y, e.new_y));
        if (got.new_z !== e.new_z)
          report($sformatf("beat %0d new_z got %h want %h", checked, got.new_z, e.new_z));
        if (got.saturated !== e.saturated)
          report($sformatf("beat %0d saturated got %b want %b", checked, got.saturated,
                           e.saturated));
      end
      checked++;
    endtask

    function int pending();
      return awaited_vel.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  velocity_board sb;

  // Set by the stimulus for a phase that runs with no idling on either side.
  bit calm = 1'b0;
  bit held = 1'b0;
  int quiet = 0;
  int settings = 0;

  always #6 clk = ~clk;

  langevin_velocity_update #(
    .VEL_FRAC_BITS(VEL_FRAC)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  // Results are sampled at the edge at which they are taken, so they see the
  // values from before any assignment made at that edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_data);
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: runs of free cycles and runs of stall, most short and a few long.
  // Once, after 300 results and inside the phase with no idling, it holds off
  // while the sender keeps offering, so the output register and then the input
  // side fill up.
  initial begin
    bit level;
    int span;
    int pick;
    wait (rst_n);
    forever begin
      if (!held && calm && sb.checked >= 300) begin
        held = 1'b1;
        level = 1'b1;
        span = 400;
      end else if (calm) begin
        level = 1'b0;
        span = 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          level = 1'b0;
          span = $urandom_range(1, 8);
        end else if (pick < 92) begin
          level = 1'b1;
          span = $urandom_range(1, 4);
        end else begin
          level = 1'b1;
          span = $urandom_range(15, 60);
        end
      end
      repeat (span) begin
        @(posedge clk);
        out_stall <= level;
      end
    end
  end

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic in_beat_t mk_beat(bit act, logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z);
    in_beat_t b;
    b.action = act;
    b.vel_x = x;
    b.vel_y = y;
    b.vel_z = z;
    return b;
  endfunction

  // Full-range words about half the time, otherwise mostly physical-looking velocities and some extremes.
  function automatic logic signed [31:0] rand_vel();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 4))
          0: return VEL_MAX;
          1: return VEL_MIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2, 3, 4: return $signed($urandom) >>> $urandom_range(8, 24);
      default: return $signed($urandom);
    endcase
  endfunction

  // Offers one beat after an optional gap and returns at the edge that takes it.
  // Valid stays high into the next beat when there is no gap.
  task automatic send_beat(in_beat_t b, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Writes all three registers back to back, optionally followed by a write to
  // the unused index, then drops the enable.
  task automatic load_settings(logic [31:0] g, logic [31:0] t, logic [31:0] n, bit junk);
    write_reg(REG_DAMPING_RATE, g);
    write_reg(REG_TIME_STEP, t);
    write_reg(REG_NOISE_STRENGTH, n);
    if (junk) write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Every beat yields one result, so once none are outstanding the block is
  // idle; the task still waits on past that to cover its pipeline anyway.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [31:0] g;
    logic [31:0] t;
    logic [31:0] n;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: no damping, unit step, no noise. Velocities pass through
    // unchanged, while noisy beats still advance the generator.
    send_beat(mk_beat(1'b0, VEL_MAX, VEL_MIN, 0), 0);
    send_beat(mk_beat(1'b0, -1, 1, 32'sh00010000), 0);
    send_beat(mk_beat(1'b1, 0, VEL_MAX, VEL_MIN), 2);
    send_beat(mk_beat(1'b1, 32'sh00010000, -32'sh00010000, 5), 0);
    drain();

    // Moderate damping and noise; the write to the unused index must not land.
    load_settings(32'hAB008000, 32'h00010000, 32'h00030000, 1'b1);
    send_beat(mk_beat(1'b0, 32'sh00010000, -32'sh00010000, 32'sh12345678), 0);
    send_beat(mk_beat(1'b1, 32'sh00010000, -32'sh00010000, 32'sh12345678), 0);
    send_beat(mk_beat(1'b1, VEL_MIN, VEL_MAX, 0), 1);
    drain();

    // Largest damping: the factor on v is hugely negative and saturates.
    load_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b0);
    send_beat(mk_beat(1'b0, VEL_MAX, VEL_MIN, 1), 0);
    send_beat(mk_beat(1'b0, -1, 0, 1), 0);
    send_beat(mk_beat(1'b1, 32'sh100, -32'sh100, 0), 0);
    drain();

    // gamma*dt/2 exactly one: damping alone cancels the velocity.
    load_settings(32'h00020000, 32'h00010000, 32'h00010000, 1'b0);
    send_beat(mk_beat(1'b0, VEL_MAX, VEL_MIN, 1), 0);
    send_beat(mk_beat(1'b1, VEL_MAX, VEL_MIN, 1), 0);
    drain();

    // Strongest noise with no damping: the noise term alone saturates.
    load_settings(32'h0, 32'h00FFFFFF, 32'hFFFFFFFF, 1'b1);
    send_beat(mk_beat(1'b1, 0, VEL_MAX, VEL_MIN), 0);
    send_beat(mk_beat(1'b1, 0, VEL_MAX, VEL_MIN), 0);
    send_beat(mk_beat(1'b1, -1, 1, 0), 0);
    send_beat(mk_beat(1'b0, VEL_MAX, VEL_MIN, -1), 0);
    drain();

    // Zero time step: no damping and no noise whatever c is.
    load_settings(32'h00FFFFFF, 32'h0, 32'hFFFFFFFF, 1'b0);
    send_beat(mk_beat(1'b1, VEL_MAX, VEL_MIN, 32'sh7), 0);
    send_beat(mk_beat(1'b0, VEL_MIN, VEL_MAX, -32'sh7), 0);
    drain();

    // Random phases, each with its own settings. Phase 2 runs with no idling,
    // and the long output hold-off falls in it.
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0: begin
          g = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
          t = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
          n = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
        end
        1: begin
          g = $urandom;
          t = $urandom;
          n = $urandom;
        end
        default: begin
          g = {8'($urandom), 24'($urandom_range(0, 24'h040000))};
          t = {8'($urandom), 24'($urandom_range(24'h000040, 24'h004000))};
          n = $urandom_range(0, 32'h00400000);
        end
      endcase
      load_settings(g, t, n, $urandom_range(0, 3) == 0);
      calm = (phase == 2);
      for (int item = 0; item < 119; item++) begin
        send_beat(mk_beat(1'($urandom_range(0, 1)), rand_vel(), rand_vel(), rand_vel()),
                  sender_gap());
      end
      drain();
    end

    $display("tb: summary: %0d beats checked, %0d with noise, %0d saturated", sb.checked,
             sb.noisy, sb.clipped);
    $display("tb: summary: %0d register settings including extremes and one long hold-off",
             settings);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
